>>> sv/fmq_pkg.sv
// Shared constants and types for the FIFO with membership query.
// Holds the default sizes, operation codes and status codes. No dependencies.
`default_nettype none

package fmq_pkg;

  // Default sizes for the top level.
  localparam int FMQ_DEPTH       = 64;
  localparam int FMQ_VALUE_WIDTH = 32;

  // Fixed widths of the request and result fields.
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes.
  localparam op_t OP_PUSH  = 3'd0;
  localparam op_t OP_POP   = 3'd1;
  localparam op_t OP_PEEK  = 3'd2;
  localparam op_t OP_QUERY = 3'd3;
  localparam op_t OP_CLEAR = 3'd4;

  // Result status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

>>> sv/fmq_store.sv
// Entry memory of the queue: one write port and one read port, registered read data.
// Depends on fmq_pkg for its default sizes; sized by its parameters.
`default_nettype none

module fmq_store import fmq_pkg::*; #(
  parameter int DEPTH       = FMQ_DEPTH,
  parameter int VALUE_WIDTH = FMQ_VALUE_WIDTH,
  localparam int AW         = $clog2(DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [VALUE_WIDTH-1:0] wdata,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          raddr,
  output logic      [VALUE_WIDTH-1:0] rdata
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/fmq_ctrl.sv
// Queue controller: head and count registers, request sequencing, membership scan
// and the result registers. Depends on fmq_pkg and drives the fmq_store ports.
`default_nettype none

module fmq_ctrl import fmq_pkg::*; #(
  parameter int DEPTH       = FMQ_DEPTH,
  parameter int VALUE_WIDTH = FMQ_VALUE_WIDTH,
  localparam int AW         = $clog2(DEPTH),
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // Request channel.
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire op_t                    operation,
  input  wire logic [DATA_W-1:0]      value,
  // Result channel.
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic      [DATA_W-1:0]      read_value,
  output logic                        found,
  output status_t                     status,
  output logic      [CW-1:0]          count,
  // Entry memory.
  output logic                        mem_we,
  output logic      [AW-1:0]          mem_waddr,
  output logic      [VALUE_WIDTH-1:0] mem_wdata,
  output logic                        mem_re,
  output logic      [AW-1:0]          mem_raddr,
  input  wire logic [VALUE_WIDTH-1:0] mem_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  // Control state.
  logic [1:0]    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [AW-1:0] ptr, ptr_next;
  logic [CW-1:0] rem, rem_next;
  logic          res_valid;

  // Per-request payload.
  op_t                    op_q;
  logic [VALUE_WIDTH-1:0] key;
  logic [DATA_W-1:0]      res_value;
  logic                   res_found;
  status_t                res_status;
  logic [CW-1:0]          res_count;

  logic                   in_acc;
  logic                   res_move;
  logic [AW:0]            tail_sum;
  logic [AW-1:0]          tail;
  logic [VALUE_WIDTH-1:0] key_in;
  logic                   fin;
  logic [DATA_W-1:0]      fin_value;
  logic                   fin_found;
  status_t                fin_status;
  logic                   hit;

  // Next slot round the circular buffer.
  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] p);
    slot_inc = (p == LAST_SLOT) ? '0 : p + AW'(1);
  endfunction

  // Handshakes: a new request is taken once the previous result has left the
  // internal result register, so a stalled output still lets one request in.
  assign res_move = res_valid && (!out_valid || !out_stall);
  assign in_stall = (state != S_IDLE) || (res_valid && !res_move);
  assign in_acc   = in_valid && !in_stall;

  // Tail slot is head plus count, wrapped with one compare and subtract.
  assign tail_sum = {1'b0, head} + (AW + 1)'(cnt);
  assign tail     = (tail_sum >= DEPTH_SUM) ? AW'(tail_sum - DEPTH_SUM) : AW'(tail_sum);
  assign key_in   = VALUE_WIDTH'(value);
  assign hit      = (mem_rdata == key);

  // Sequencer: memory accesses are serialised, so a write and a read never
  // meet on the same edge and no forwarding is needed.
  always_comb begin
    state_next = state;
    head_next  = head;
    cnt_next   = cnt;
    ptr_next   = ptr;
    rem_next   = rem;
    mem_we     = 1'b0;
    mem_waddr  = tail;
    mem_wdata  = key_in;
    mem_re     = 1'b0;
    mem_raddr  = head;
    fin        = 1'b0;
    fin_value  = '0;
    fin_found  = 1'b0;
    fin_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (operation)
            OP_PUSH: begin
              fin = 1'b1;
              if (cnt == DEPTH_CNT) begin
                fin_status = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                cnt_next = cnt + CW'(1);
              end
            end
            OP_POP, OP_PEEK: begin
              if (cnt == '0) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                state_next = S_READ;
              end
            end
            OP_QUERY: begin
              if (cnt == '0) begin
                fin = 1'b1;
              end else begin
                mem_re     = 1'b1;
                ptr_next   = slot_inc(head);
                rem_next   = cnt;
                state_next = S_SCAN;
              end
            end
            OP_CLEAR: begin
              fin       = 1'b1;
              head_next = '0;
              cnt_next  = '0;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin        = 1'b1;
        fin_value  = DATA_W'(mem_rdata);
        fin_found  = 1'b1;
        state_next = S_IDLE;
        if (op_q == OP_POP) begin
          head_next = slot_inc(head);
          cnt_next  = cnt - CW'(1);
        end
      end
      S_SCAN: begin
        // One entry compared per cycle while the next read is under way.
        if (hit || (rem == CW'(1))) begin
          fin        = 1'b1;
          fin_found  = hit;
          state_next = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr;
          ptr_next  = slot_inc(ptr);
          rem_next  = rem - CW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      cnt       <= '0;
      ptr       <= '0;
      rem       <= '0;
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      ptr   <= ptr_next;
      rem   <= rem_next;
      if (fin) begin
        res_valid <= 1'b1;
      end else if (res_move) begin
        res_valid <= 1'b0;
      end
      if (res_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q <= operation;
      key  <= key_in;
    end
    if (fin) begin
      res_value  <= fin_value;
      res_found  <= fin_found;
      res_status <= fin_status;
      res_count  <= cnt_next;
    end
    if (res_move) begin
      read_value <= res_value;
      found      <= res_found;
      status     <= res_status;
      count      <= res_count;
    end
  end

endmodule

`default_nettype wire

>>> sv/fifo_with_membership_query.sv
// Top level of the FIFO with membership query.
// Depends on fmq_pkg, fmq_store and fmq_ctrl.
//
// A first-in first-out queue of up to DEPTH values held in a single-port-read,
// single-port-write synchronous memory. Each request carries one operation
// (push, pop, peek, membership query or clear) and yields exactly one result
// with the value read, a found flag, a status and the count after the operation.
// Push, clear and unused codes finish in the cycle they are taken, so a stream of
// them runs at one request per cycle while the output is not stalled. Pop and peek
// pass through a read state to wait for the memory's registered read data. A
// membership query reads the occupied entries one per cycle from the oldest,
// through the single read port, stopping at the first hit. A result passes
// through the internal result register into the output registers, and one
// further request is taken while a result is held by out_stall. There is no
// clearing pass after reset: entries outside the occupied range are never read.
`default_nettype none

module fifo_with_membership_query import fmq_pkg::*; #(
  parameter int DEPTH       = FMQ_DEPTH,
  parameter int VALUE_WIDTH = FMQ_VALUE_WIDTH,
  localparam int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire op_t               operation,
  input  wire logic [DATA_W-1:0] value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [DATA_W-1:0] read_value,
  output logic                   found,
  output status_t                status,
  output logic      [CW-1:0]     count
);

  localparam int AW = $clog2(DEPTH);

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  // Sequencer and result registers.
  fmq_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .found      (found),
    .status     (status),
    .count      (count),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Entry storage.
  fmq_store #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

>>> sv/fmq_checker.sv
// Port-level checks for the FIFO with membership query, and the bind that
// attaches them to the top level. Depends on fmq_pkg.
`default_nettype none

module fmq_checker import fmq_pkg::*; #(
  parameter int DEPTH = FMQ_DEPTH,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [DATA_W-1:0] read_value,
  input wire logic              found,
  input wire status_t           status,
  input wire logic [CW-1:0]     count
);

  // A stalled result stays offered.
  a_out_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result does not change.
  a_out_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(read_value) && $stable(found) &&
                               $stable(status) && $stable(count))
    else $error("stalled result changed");

  // An empty report means an empty queue and no value.
  a_empty_means_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> (count == '0) && !found && (read_value == '0))
    else $error("empty status with entries or a value");

  // A dropped push only happens on a full queue.
  a_full_means_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (count == CW'(DEPTH)) && !found)
    else $error("full status below depth");

  // A non-zero value is only returned by a successful pop or peek.
  a_value_needs_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (read_value != '0) |-> found && (status == ST_OK))
    else $error("value returned without a valid read");

endmodule

bind fifo_with_membership_query fmq_checker #(.DEPTH(DEPTH)) u_fmq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_value (read_value),
  .found      (found),
  .status     (status),
  .count      (count)
);

`default_nettype wire
